FILE: rtl/sitda_pkg.sv
// Shared constants and helpers for the signed integer to decimal ASCII converter.
package sitda_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CHAR_W     = 6;
    localparam int LEN_W      = 4;
    localparam int CNT_W      = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // Correct one BCD digit before a doubling step: add three when five or more.
    function automatic logic [3:0] dabble_fix(input logic [3:0] d);
        dabble_fix = (d >= 4'd5) ? (d + 4'd3) : d;
    endfunction

endpackage

FILE: rtl/sitda_dabble.sv
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
module sitda_dabble (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [sitda_pkg::VALUE_W-1:0] mag,
    output logic [sitda_pkg::BCD_W-1:0]   bcd,
    output logic                          done
);
    import sitda_pkg::*;

    logic [VALUE_W-1:0] mag_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_fixed;
    logic [CNT_W-1:0]   cnt_reg;
    logic               run_reg;
    logic               done_reg;

    // Correct every digit independently before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_fixed[4*i +: 4] = dabble_fix(bcd_reg[4*i +: 4]);
        end
    end

    // Hold sequencing control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the magnitude out MSB first into the BCD register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg <= mag;
            bcd_reg <= '0;
        end
        else if (run_reg)
        begin
            mag_reg <= {mag_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= {bcd_fixed[BCD_W-2:0], mag_reg[VALUE_W-1]};
        end
    end

    assign bcd  = bcd_reg;
    assign done = done_reg;

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
// Raise start with value while busy is low; the item is taken at that edge and
// busy stays high until the last character has been scheduled. The magnitude
// goes through a bit-serial shift-and-add-3 converter, then leading zero
// digits are dropped one per cycle (up to 9 of them), then characters come
// out one per cycle on consecutive cycles: '-' first for negative values, then
// the digits most significant first. Each character is on ascii_char,
// string_length and last_char for exactly one cycle with strobe high; the
// receiver cannot stall, so it must take every strobe. A new start is taken
// in the cycle the last character shows.
module signed_int_to_decimal_ascii (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [sitda_pkg::VALUE_W-1:0] value,
    output logic                               busy,
    output logic                               strobe,
    output logic [sitda_pkg::CHAR_W-1:0]       ascii_char,
    output logic [sitda_pkg::LEN_W-1:0]        string_length,
    output logic                               last_char
);
    import sitda_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t             state_reg;
    logic               neg_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [LEN_W-1:0]   left_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               strobe_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [LEN_W-1:0]   slen_reg;
    logic               last_reg;

    logic               accept;
    logic [VALUE_W-1:0] mag;
    logic [BCD_W-1:0]   conv_bcd;
    logic               conv_done;
    logic [3:0]         top_digit;

    assign accept    = start && (state_reg == ST_IDLE);
    assign mag       = value[VALUE_W-1] ? (~value + 1'b1) : value;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    sitda_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .mag   (mag),
        .bcd   (conv_bcd),
        .done  (conv_done)
    );

    // Sequence conversion, zero skipping and character emission
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            neg_reg    <= 1'b0;
            bcd_reg    <= '0;
            left_reg   <= '0;
            len_reg    <= '0;
            strobe_reg <= 1'b0;
            char_reg   <= '0;
            slen_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg   <= value[VALUE_W-1];
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    if (conv_done)
                    begin
                        bcd_reg   <= conv_bcd;
                        left_reg  <= LEN_W'(NUM_DIGITS);
                        state_reg <= ST_SKIP;
                    end
                end
                ST_SKIP:
                begin
                    // Drop leading zero digits, keeping at least one
                    if (top_digit == 4'd0 && left_reg > 4'd1)
                    begin
                        bcd_reg  <= {bcd_reg[BCD_W-5:0], 4'd0};
                        left_reg <= left_reg - 1'b1;
                    end
                    else
                    begin
                        len_reg   <= left_reg + {{(LEN_W-1){1'b0}}, neg_reg};
                        state_reg <= neg_reg ? ST_SIGN : ST_DIGIT;
                    end
                end
                ST_SIGN:
                begin
                    strobe_reg <= 1'b1;
                    char_reg   <= CHAR_MINUS;
                    slen_reg   <= len_reg;
                    last_reg   <= 1'b0;
                    state_reg  <= ST_DIGIT;
                end
                ST_DIGIT:
                begin
                    strobe_reg <= 1'b1;
                    char_reg   <= CHAR_ZERO + {2'b00, top_digit};
                    slen_reg   <= len_reg;
                    last_reg   <= (left_reg == 4'd1);
                    bcd_reg    <= {bcd_reg[BCD_W-5:0], 4'd0};
                    left_reg   <= left_reg - 1'b1;
                    if (left_reg == 4'd1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign strobe        = strobe_reg;
    assign ascii_char    = char_reg;
    assign string_length = slen_reg;
    assign last_char     = last_reg;

endmodule

FILE: rtl/sitda_checker.sv
// Port-level checks for the integer to ASCII converter, bound to the top level.
module sitda_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 strobe,
    input logic [sitda_pkg::CHAR_W-1:0]         ascii_char,
    input logic [sitda_pkg::LEN_W-1:0]          string_length,
    input logic                                 last_char
);
    import sitda_pkg::*;

    // Characters of one item come on consecutive cycles
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_char |=> strobe)
        else $error("character run broken before last character");

    // Nothing follows the last character directly
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_char |=> !strobe)
        else $error("strobe right after last character");

    // Length stays fixed within one item
    a_len_stable: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_char |=> string_length == $past(string_length))
        else $error("string length changed within an item");

    // Only a minus sign or a decimal digit is emitted
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (ascii_char == CHAR_MINUS) ||
                   (ascii_char >= CHAR_ZERO && ascii_char <= CHAR_ZERO + 6'd9))
        else $error("illegal character");

    // An accepted item makes the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted item");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);
